FILE: sv/m2a_pkg.sv
// shared types, constants and helper functions of the 2x2 fixed point matrix unit
// no dependencies; every other file of the block uses it by scoped names
package m2a_pkg;

    localparam int FRAC_BITS = 16;
    // truncated product width, sum width, divider numerator and divisor widths
    localparam int PRD_W = 64 - FRAC_BITS;
    localparam int SUM_W = PRD_W + 1;
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int DEN_W = SUM_W;

    localparam logic [63:0] RND_BIAS = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] S_MIN = ~S_MAX;
    localparam logic [NUM_W-1:0] QPOS_MAX = NUM_W'(64'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] QNEG_MAX = NUM_W'(64'h8000_0000);

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_SUB    = 3'd1,
        MODE_MUL    = 3'd2,
        MODE_XFORM  = 3'd3,
        MODE_TRANSP = 3'd4,
        MODE_INV    = 3'd5,
        MODE_NEG    = 3'd6,
        MODE_DET    = 3'd7
    } t_mode;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] mat_a_00;
        logic signed [31:0] mat_a_01;
        logic signed [31:0] mat_a_10;
        logic signed [31:0] mat_a_11;
        logic signed [31:0] mat_b_00;
        logic signed [31:0] mat_b_01;
        logic signed [31:0] mat_b_10;
        logic signed [31:0] mat_b_11;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] res_00;
        logic signed [31:0] res_01;
        logic signed [31:0] res_10;
        logic signed [31:0] res_11;
        logic               singular;
        logic               overflow;
    } t_out_beat;

    // element index: 0 = 00, 1 = 01, 2 = 10, 3 = 11
    typedef struct packed {
        t_mode            mode;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic [7:0][31:0] x;
        logic [7:0][31:0] y;
    } t_opnd;

    typedef struct packed {
        t_mode            mode;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic [7:0][63:0] p;
    } t_prod;

    typedef struct packed {
        t_mode                 mode;
        logic [3:0][31:0]      a;
        logic [3:0][31:0]      b;
        logic [7:0][PRD_W-1:0] t;
    } t_trnc;

    typedef struct packed {
        t_mode                 mode;
        logic [3:0][SUM_W-1:0] rc;
        logic [SUM_W-1:0]      d;
        logic                  div_en;
        logic                  singular;
    } t_cand;

    typedef struct packed {
        t_mode                 mode;
        logic [3:0][SUM_W-1:0] rc;
        logic                  div_en;
        logic                  singular;
        logic [3:0]            q_neg;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } t_dstep;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } t_sat;

    function automatic logic [SUM_W-1:0] ext32(input logic [31:0] v);
        return SUM_W'($signed(v));
    endfunction

    function automatic logic [SUM_W-1:0] ext_prd(input logic [PRD_W-1:0] v);
        return SUM_W'($signed(v));
    endfunction

    function automatic logic [NUM_W-1:0] mag_num(input logic [31:0] m);
        return NUM_W'(m) << FRAC_BITS;
    endfunction

    // one restoring step: numerator bits shift out of nq as quotient bits shift in
    function automatic t_dstep div_step(input logic [DEN_W-1:0] rem,
                                        input logic [NUM_W-1:0] nq,
                                        input logic [DEN_W-1:0] den);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        t_dstep         o;
        trial = {rem, nq[NUM_W-1]};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            o.rem = diff[DEN_W-1:0];
            o.nq  = {nq[NUM_W-2:0], 1'b1};
        end else begin
            o.rem = trial[DEN_W-1:0];
            o.nq  = {nq[NUM_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_sat sat32(input logic [SUM_W-1:0] v);
        t_sat o;
        o.ovf = 1'b0;
        o.val = v[31:0];
        if ($signed(v) > S_MAX) begin
            o.val = 32'h7FFF_FFFF;
            o.ovf = 1'b1;
        end else if ($signed(v) < S_MIN) begin
            o.val = 32'h8000_0000;
            o.ovf = 1'b1;
        end
        return o;
    endfunction

    function automatic t_sat sat_quot(input logic [NUM_W-1:0] mag, input logic neg);
        t_sat o;
        o.ovf = 1'b0;
        if (neg) begin
            o.val = ~mag[31:0] + 32'd1;
            if (mag > QNEG_MAX) begin
                o.val = 32'h8000_0000;
                o.ovf = 1'b1;
            end
        end else begin
            o.val = mag[31:0];
            if (mag > QPOS_MAX) begin
                o.val = 32'h7FFF_FFFF;
                o.ovf = 1'b1;
            end
        end
        return o;
    endfunction

endpackage

FILE: sv/m2a_mul.sv
// input capture with operand selection, then eight 32x32 signed multipliers
// depends on m2a_pkg
module m2a_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  m2a_pkg::t_in_beat i_beat,
    output logic             o_vld,
    output m2a_pkg::t_prod   o_prod
);

    m2a_pkg::t_opnd n_opnd;
    m2a_pkg::t_opnd r_opnd;
    logic           r_vld_a;
    m2a_pkg::t_prod n_prod;
    m2a_pkg::t_prod r_prod;
    logic           r_vld_b;

    always_comb begin
        logic [31:0] v0;
        logic [31:0] v1;
        n_opnd.mode = m2a_pkg::t_mode'(i_beat.mode);
        n_opnd.a    = {i_beat.mat_a_11, i_beat.mat_a_10, i_beat.mat_a_01, i_beat.mat_a_00};
        n_opnd.b    = {i_beat.mat_b_11, i_beat.mat_b_10, i_beat.mat_b_01, i_beat.mat_b_00};
        v0 = (n_opnd.mode == m2a_pkg::MODE_XFORM) ? i_beat.vec_x : i_beat.mat_b_00;
        v1 = (n_opnd.mode == m2a_pkg::MODE_XFORM) ? i_beat.vec_y : i_beat.mat_b_01;
        // column-major pairs, summed two by two downstream
        n_opnd.x[0] = i_beat.mat_a_00;  n_opnd.y[0] = v0;
        n_opnd.x[1] = i_beat.mat_a_10;  n_opnd.y[1] = v1;
        n_opnd.x[2] = i_beat.mat_a_01;  n_opnd.y[2] = v0;
        n_opnd.x[3] = i_beat.mat_a_11;  n_opnd.y[3] = v1;
        n_opnd.x[4] = i_beat.mat_a_00;  n_opnd.y[4] = i_beat.mat_b_10;
        n_opnd.x[5] = i_beat.mat_a_10;  n_opnd.y[5] = i_beat.mat_b_11;
        n_opnd.x[6] = i_beat.mat_a_01;  n_opnd.y[6] = i_beat.mat_b_10;
        n_opnd.x[7] = i_beat.mat_a_11;  n_opnd.y[7] = i_beat.mat_b_11;
        // determinant terms in the first pair
        if (n_opnd.mode == m2a_pkg::MODE_DET || n_opnd.mode == m2a_pkg::MODE_INV) begin
            n_opnd.y[0] = i_beat.mat_a_11;
            n_opnd.x[1] = i_beat.mat_a_01;
            n_opnd.y[1] = i_beat.mat_a_10;
        end
    end

    always_comb begin
        n_prod.mode = r_opnd.mode;
        n_prod.a    = r_opnd.a;
        n_prod.b    = r_opnd.b;
        for (int k = 0; k < 8; k++) begin
            n_prod.p[k] = 64'($signed(r_opnd.x[k]) * $signed(r_opnd.y[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_adv) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_opnd <= n_opnd;
            r_prod <= n_prod;
        end
    end

    assign o_vld  = r_vld_b;
    assign o_prod = r_prod;

endmodule

FILE: sv/m2a_sum.sv
// product truncation toward zero, then per-mode sums, determinant and candidates
// depends on m2a_pkg
module m2a_sum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  m2a_pkg::t_prod i_prod,
    output logic           o_vld,
    output m2a_pkg::t_cand o_cand
);

    m2a_pkg::t_trnc n_trnc;
    m2a_pkg::t_trnc r_trnc;
    logic           r_vld_t;
    m2a_pkg::t_cand n_cand;
    m2a_pkg::t_cand r_cand;
    logic           r_vld_c;

    always_comb begin
        logic [63:0] s;
        n_trnc.mode = i_prod.mode;
        n_trnc.a    = i_prod.a;
        n_trnc.b    = i_prod.b;
        for (int k = 0; k < 8; k++) begin
            s = i_prod.p[k] + (i_prod.p[k][63] ? m2a_pkg::RND_BIAS : 64'd0);
            n_trnc.t[k] = s[63:m2a_pkg::FRAC_BITS];
        end
    end

    always_comb begin
        logic [3:0][m2a_pkg::SUM_W-1:0] ea;
        logic [3:0][m2a_pkg::SUM_W-1:0] eb;
        logic [3:0][m2a_pkg::SUM_W-1:0] sm;
        logic [m2a_pkg::SUM_W-1:0]      dv;
        for (int i = 0; i < 4; i++) begin
            ea[i] = m2a_pkg::ext32(r_trnc.a[i]);
            eb[i] = m2a_pkg::ext32(r_trnc.b[i]);
            sm[i] = m2a_pkg::ext_prd(r_trnc.t[2*i]) + m2a_pkg::ext_prd(r_trnc.t[2*i+1]);
        end
        dv = m2a_pkg::ext_prd(r_trnc.t[0]) - m2a_pkg::ext_prd(r_trnc.t[1]);
        n_cand.mode     = r_trnc.mode;
        n_cand.d        = dv;
        n_cand.rc       = '0;
        n_cand.div_en   = 1'b0;
        n_cand.singular = 1'b0;
        case (r_trnc.mode)
            m2a_pkg::MODE_ADD: begin
                for (int i = 0; i < 4; i++) n_cand.rc[i] = ea[i] + eb[i];
            end
            m2a_pkg::MODE_SUB: begin
                for (int i = 0; i < 4; i++) n_cand.rc[i] = ea[i] - eb[i];
            end
            m2a_pkg::MODE_MUL: begin
                n_cand.rc = sm;
            end
            m2a_pkg::MODE_XFORM: begin
                n_cand.rc[0] = sm[0];
                n_cand.rc[1] = sm[1];
            end
            m2a_pkg::MODE_TRANSP: begin
                n_cand.rc = {ea[3], ea[1], ea[2], ea[0]};
            end
            m2a_pkg::MODE_INV: begin
                if (dv == '0) begin
                    n_cand.rc       = ea;
                    n_cand.singular = 1'b1;
                end else begin
                    n_cand.rc     = {ea[0], -ea[2], -ea[1], ea[3]};
                    n_cand.div_en = 1'b1;
                end
            end
            m2a_pkg::MODE_NEG: begin
                for (int i = 0; i < 4; i++) n_cand.rc[i] = -ea[i];
            end
            m2a_pkg::MODE_DET: begin
                n_cand.rc[0] = dv;
            end
            default: begin
                n_cand.rc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_t <= 1'b0;
            r_vld_c <= 1'b0;
        end else if (i_adv) begin
            r_vld_t <= i_vld;
            r_vld_c <= r_vld_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_trnc <= n_trnc;
            r_cand <= n_cand;
        end
    end

    assign o_vld  = r_vld_c;
    assign o_cand = r_cand;

endmodule

FILE: sv/m2a_div.sv
// four-lane pipelined restoring divider, one quotient bit per stage
// depends on m2a_pkg; non-dividing beats ride along in the side data
module m2a_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_vld,
    input  m2a_pkg::t_cand                    i_cand,
    output logic                              o_vld,
    output m2a_pkg::t_side                    o_side,
    output logic [3:0][m2a_pkg::NUM_W-1:0]    o_quot
);

    localparam int STEPS = m2a_pkg::NUM_W;

    logic                       r_vld  [STEPS+1];
    m2a_pkg::t_side             r_side [STEPS+1];
    logic [m2a_pkg::DEN_W-1:0]  r_den  [STEPS];
    logic [m2a_pkg::DEN_W-1:0]  r_rem  [STEPS][4];
    logic [m2a_pkg::NUM_W-1:0]  r_nq   [STEPS+1][4];

    m2a_pkg::t_side             n_side;
    logic [m2a_pkg::DEN_W-1:0]  n_den;
    logic [m2a_pkg::NUM_W-1:0]  n_nq [4];

    // magnitudes and quotient signs
    always_comb begin
        logic [m2a_pkg::SUM_W-1:0] m;
        n_den = i_cand.d[m2a_pkg::SUM_W-1] ? (~i_cand.d + 1'b1) : i_cand.d;
        n_side.mode     = i_cand.mode;
        n_side.rc       = i_cand.rc;
        n_side.div_en   = i_cand.div_en;
        n_side.singular = i_cand.singular;
        for (int i = 0; i < 4; i++) begin
            m = i_cand.rc[i][m2a_pkg::SUM_W-1] ? (~i_cand.rc[i] + 1'b1) : i_cand.rc[i];
            n_nq[i] = m2a_pkg::mag_num(m[31:0]);
            n_side.q_neg[i] = i_cand.rc[i][m2a_pkg::SUM_W-1] ^ i_cand.d[m2a_pkg::SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= n_side;
            r_den[0]  <= n_den;
            for (int i = 0; i < 4; i++) begin
                r_rem[0][i] <= '0;
                r_nq[0][i]  <= n_nq[i];
            end
        end
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        m2a_pkg::t_dstep n_st [4];

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                n_st[i] = m2a_pkg::div_step(r_rem[s][i], r_nq[s][i], r_den[s]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[s+1] <= r_side[s];
                for (int i = 0; i < 4; i++) begin
                    r_nq[s+1][i] <= n_st[i].nq;
                end
            end
        end

        if (s < STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_den[s+1] <= r_den[s];
                    for (int i = 0; i < 4; i++) begin
                        r_rem[s+1][i] <= n_st[i].rem;
                    end
                end
            end
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_side = r_side[STEPS];
    always_comb begin
        for (int i = 0; i < 4; i++) o_quot[i] = r_nq[STEPS][i];
    end

endmodule

FILE: sv/matrix2x2_fixed_alu.sv
// top level of the 2x2 signed fixed point matrix unit: pipeline and output register
// depends on m2a_pkg, m2a_mul, m2a_sum, m2a_div
//
// usage
//   input channel: i_valid / o_stall carry one beat of t_in_beat (mode, A, B, vector);
//   a beat is taken at a rising edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall carry one beat of t_out_beat (four elements,
//   singular, overflow); a beat leaves at an edge with o_valid high and i_stall low
//   every input beat yields exactly one output beat, in order
//   throughput: one beat per cycle, every mode, while the receiver takes results
//   ordering: every mode passes through the divider, which resolves one quotient
//   bit per stage, so that results stay in order
//   stages: operand select, multiply, truncate, sum/determinant, divider prep,
//   NUM_W divider steps, saturate into the output register
//   stall: while a result sits in the output register and i_stall is high, the
//   whole pipeline holds in place and o_stall is raised in the same cycle; no beat
//   is dropped or repeated
//   reset: synchronous, active low; clears all stage valid bits, o_valid goes low
module matrix2x2_fixed_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  m2a_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output m2a_pkg::t_out_beat o_data
);

    // pipeline advance: output empty or being taken
    logic adv;

    logic           mul_vld;
    m2a_pkg::t_prod mul_prod;
    logic           sum_vld;
    m2a_pkg::t_cand sum_cand;
    logic           div_vld;
    m2a_pkg::t_side div_side;
    logic [3:0][m2a_pkg::NUM_W-1:0] div_quot;

    m2a_pkg::t_out_beat n_out;
    m2a_pkg::t_out_beat r_out;
    logic               r_out_vld;

    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = !adv;

    m2a_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (i_valid),
        .i_beat  (i_data),
        .o_vld   (mul_vld),
        .o_prod  (mul_prod)
    );

    m2a_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (mul_vld),
        .i_prod  (mul_prod),
        .o_vld   (sum_vld),
        .o_cand  (sum_cand)
    );

    m2a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (sum_vld),
        .i_cand  (sum_cand),
        .o_vld   (div_vld),
        .o_side  (div_side),
        .o_quot  (div_quot)
    );

    // pick quotient or candidate per lane, then saturate to 32 bits
    always_comb begin
        m2a_pkg::t_sat    st [4];
        logic [3:0]       ovf;
        for (int i = 0; i < 4; i++) begin
            if (div_side.div_en) begin
                st[i] = m2a_pkg::sat_quot(div_quot[i], div_side.q_neg[i]);
            end else begin
                st[i] = m2a_pkg::sat32(div_side.rc[i]);
            end
            ovf[i] = st[i].ovf;
        end
        n_out.res_00   = st[0].val;
        n_out.res_01   = st[1].val;
        n_out.res_10   = st[2].val;
        n_out.res_11   = st[3].val;
        n_out.singular = div_side.singular;
        n_out.overflow = |ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && div_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // a singular invert never runs the divider
    a_sing_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_vld && div_side.singular |-> !div_side.div_en)
        else $error("singular beat marked for division");

    // only invert uses the quotients
    a_div_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_vld && div_side.div_en |-> div_side.mode == m2a_pkg::MODE_INV)
        else $error("division enabled outside invert");

    // transpose moves elements only, nothing can saturate
    a_transp_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_vld && div_side.mode == m2a_pkg::MODE_TRANSP |-> !n_out.overflow)
        else $error("overflow on transpose");

    // a singular result returns A unchanged and cannot overflow
    a_sing_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> !o_data.overflow)
        else $error("overflow with singular result");

endmodule

FILE: dv/tb_top.sv
// self-checking bench for the 2x2 fixed point matrix unit: directed and random beats,
// every result checked field by field; depends on m2a_pkg and matrix2x2_fixed_alu
module tb_top;

    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYC  = 80;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    m2a_pkg::t_in_beat  i_data;
    logic               o_valid;
    logic               i_stall;
    m2a_pkg::t_out_beat o_data;

    matrix2x2_fixed_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // beats waiting to be driven, results waiting to come back
    m2a_pkg::t_in_beat  pend_beats[$];
    m2a_pkg::t_out_beat want_res[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  n_errors;
    int  n_sent;
    int  n_recv;
    int  n_sing;
    int  n_ovf;
    int  quiet_cyc;
    logic in_fire;

    always begin
        #10 i_clk = ~i_clk;
    end

    // q16.16 product truncated toward zero; longint division truncates the same way
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) / (longint'(1) << m2a_pkg::FRAC_BITS);
    endfunction

    function automatic m2a_pkg::t_out_beat matrix_result(m2a_pkg::t_in_beat it);
        m2a_pkg::t_out_beat r;
        longint a00, a01, a10, a11, b00, b01, b10, b11, vx, vy, det;
        longint e[4];
        logic ovf;
        a00 = it.mat_a_00; a01 = it.mat_a_01; a10 = it.mat_a_10; a11 = it.mat_a_11;
        b00 = it.mat_b_00; b01 = it.mat_b_01; b10 = it.mat_b_10; b11 = it.mat_b_11;
        vx  = it.vec_x;    vy  = it.vec_y;
        e = '{0, 0, 0, 0};
        r.singular = 1'b0;
        ovf = 1'b0;
        case (m2a_pkg::t_mode'(it.mode))
            m2a_pkg::MODE_ADD: begin
                e = '{a00 + b00, a01 + b01, a10 + b10, a11 + b11};
            end
            m2a_pkg::MODE_SUB: begin
                e = '{a00 - b00, a01 - b01, a10 - b10, a11 - b11};
            end
            m2a_pkg::MODE_MUL: begin
                // column-major sums
                e[0] = fx_mul(a00, b00) + fx_mul(a10, b01);
                e[1] = fx_mul(a01, b00) + fx_mul(a11, b01);
                e[2] = fx_mul(a00, b10) + fx_mul(a10, b11);
                e[3] = fx_mul(a01, b10) + fx_mul(a11, b11);
            end
            m2a_pkg::MODE_XFORM: begin
                e[0] = fx_mul(a00, vx) + fx_mul(a10, vy);
                e[1] = fx_mul(a01, vx) + fx_mul(a11, vy);
            end
            m2a_pkg::MODE_TRANSP: begin
                e = '{a00, a10, a01, a11};
            end
            m2a_pkg::MODE_INV: begin
                // determinant kept exact, no saturation before the divide
                det = fx_mul(a00, a11) - fx_mul(a01, a10);
                if (det == 0) begin
                    r.singular = 1'b1;
                    e = '{a00, a01, a10, a11};
                end else begin
                    e[0] = (a11 * (longint'(1) << m2a_pkg::FRAC_BITS)) / det;
                    e[1] = (-a01 * (longint'(1) << m2a_pkg::FRAC_BITS)) / det;
                    e[2] = (-a10 * (longint'(1) << m2a_pkg::FRAC_BITS)) / det;
                    e[3] = (a00 * (longint'(1) << m2a_pkg::FRAC_BITS)) / det;
                end
            end
            m2a_pkg::MODE_NEG: begin
                e = '{-a00, -a01, -a10, -a11};
            end
            default: begin
                e[0] = fx_mul(a00, a11) - fx_mul(a01, a10);
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            if (e[i] > 64'sd2147483647) begin
                e[i] = 64'sd2147483647;
                ovf = 1'b1;
            end else if (e[i] < -64'sd2147483648) begin
                e[i] = -64'sd2147483648;
                ovf = 1'b1;
            end
        end
        r.res_00 = e[0][31:0];
        r.res_01 = e[1][31:0];
        r.res_10 = e[2][31:0];
        r.res_11 = e[3][31:0];
        r.overflow = ovf;
        return r;
    endfunction

    // element values: extremes, small q16.16 values, or any 32-bit pattern
    function automatic logic [31:0] pick_elem();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return ($urandom_range(1)) ? 32'h0001_0000 : 32'hFFFF_0000;
            5, 6: return 32'($signed($urandom_range(20'hF_FFFF)) - 32'sh0008_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic m2a_pkg::t_in_beat rand_beat();
        m2a_pkg::t_in_beat it;
        it.mode     = 3'($urandom_range(7));
        it.mat_a_00 = pick_elem(); it.mat_a_01 = pick_elem();
        it.mat_a_10 = pick_elem(); it.mat_a_11 = pick_elem();
        it.mat_b_00 = pick_elem(); it.mat_b_01 = pick_elem();
        it.mat_b_10 = pick_elem(); it.mat_b_11 = pick_elem();
        it.vec_x    = pick_elem(); it.vec_y    = pick_elem();
        // push some inverts onto a singular matrix
        if (m2a_pkg::t_mode'(it.mode) == m2a_pkg::MODE_INV && $urandom_range(3) == 0) begin
            it.mat_a_01 = it.mat_a_00;
            it.mat_a_11 = it.mat_a_10;
        end
        return it;
    endfunction

    function automatic m2a_pkg::t_in_beat mk_beat(m2a_pkg::t_mode m, logic [31:0] a00,
                                                  logic [31:0] a01, logic [31:0] a10,
                                                  logic [31:0] a11, logic [31:0] bv,
                                                  logic [31:0] vv);
        m2a_pkg::t_in_beat it;
        it.mode = m;
        it.mat_a_00 = a00; it.mat_a_01 = a01; it.mat_a_10 = a10; it.mat_a_11 = a11;
        it.mat_b_00 = bv;  it.mat_b_01 = bv;  it.mat_b_10 = bv;  it.mat_b_11 = bv;
        it.vec_x    = vv;  it.vec_y    = vv;
        return it;
    endfunction

    task automatic chk_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("field %s: expected %h, got %h", fname, want, got);
            n_errors++;
        end
    endtask

    // driver: falling edge, next beat only once the current one has gone
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_fire) begin
                if (pend_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_data  <= pend_beats.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: rising edge, predict on accept, compare on delivery, watchdog
    always @(posedge i_clk) begin
        m2a_pkg::t_out_beat want;
        logic               busy;
        busy = 1'b0;
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want_res.push_back(matrix_result(i_data));
                n_sent++;
                busy = 1'b1;
            end
            if (o_valid && !i_stall) begin
                busy = 1'b1;
                n_recv++;
                if (want_res.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_errors++;
                end else begin
                    want = want_res.pop_front();
                    if (want.singular) n_sing++;
                    if (want.overflow) n_ovf++;
                    chk_field("res_00", want.res_00, o_data.res_00);
                    chk_field("res_01", want.res_01, o_data.res_01);
                    chk_field("res_10", want.res_10, o_data.res_10);
                    chk_field("res_11", want.res_11, o_data.res_11);
                    chk_field("singular", 32'(want.singular), 32'(o_data.singular));
                    chk_field("overflow", 32'(want.overflow), 32'(o_data.overflow));
                end
            end
            if (busy) begin
                quiet_cyc <= 0;
            end else begin
                quiet_cyc <= quiet_cyc + 1;
            end
            if (quiet_cyc >= WDOG_LIMIT) begin
                $display("matrix2x2_fixed_alu: mismatch");
                $finish;
            end
        end
    end

    // wait until every queued beat has gone and every result has come back
    task automatic drain();
        while (pend_beats.size() > 0 || i_valid || want_res.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) pend_beats.push_back(rand_beat());
        drain();
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        in_fire = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_errors = 0; n_sent = 0; n_recv = 0; n_sing = 0; n_ovf = 0;
        quiet_cyc = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every mode at the extremes, negated minimum, singular and
        // identity inverts, saturating products
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h0, 32'h1, 32'h7FFF_FFFF, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_ADD, 32'h8000_0000, 32'h8000_0000,
                                     32'h1, 32'h0, 32'h8000_0000, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'h0, 32'h5, 32'h7FFF_FFFF, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_SUB, 32'h7FFF_FFFF, 32'h0, 32'h3,
                                     32'h0, 32'h8000_0000, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_MUL, 32'h0001_0000, 32'h0002_0000,
                                     32'hFFFF_0000, 32'h0000_8000, 32'h0003_0000, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_MUL, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1,
                                     32'hFFFF_FFFF, 32'h0000_7FFF, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_XFORM, 32'h0001_0000, 32'h0, 32'h0,
                                     32'h0001_0000, 32'h0, 32'hFFFF_8000));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_XFORM, 32'h8000_0000, 32'h8000_0000,
                                     32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_TRANSP, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_INV, 32'h0001_0000, 32'h0, 32'h0,
                                     32'h0001_0000, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_INV, 32'h0002_0000, 32'h0001_0000,
                                     32'h0004_0000, 32'h0002_0000, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_INV, 32'h1, 32'h1, 32'h1, 32'h1,
                                     32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_INV, 32'h0000_0001, 32'h0, 32'h0,
                                     32'h0001_0000, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_INV, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_INV, 32'h0000_0100, 32'h0, 32'h0,
                                     32'h0000_0100, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_NEG, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_DET, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_DET, 32'h0003_0000, 32'h0001_0000,
                                     32'h0002_0000, 32'h0004_0000, 32'h0, 32'h0));
        pend_beats.push_back(mk_beat(m2a_pkg::MODE_DET, 32'h0, 32'h0, 32'h0, 32'h0,
                                     32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain();

        // random phases; each drain is a full pause until every result is back
        run_phase(400, 0, 0);
        run_phase(400, 86, 0);
        run_phase(400, 0, 86);
        run_phase(500, 23, 23);

        repeat (DRAIN_CYC) @(posedge i_clk);
        if (want_res.size() != 0) begin
            $error("%0d results never arrived", want_res.size());
            n_errors++;
        end
        $display("covered %0d beats sent, %0d results checked over all eight modes,",
                 n_sent, n_recv);
        $display("%0d singular inverts, %0d saturated results, four idle/stall mixes",
                 n_sing, n_ovf);
        if (n_errors == 0) begin
            $display("matrix2x2_fixed_alu: match");
        end else begin
            $display("matrix2x2_fixed_alu: mismatch");
        end
        $finish;
    end

endmodule

FILE: matrix2x2_fixed_alu.f
sv/m2a_pkg.sv
sv/m2a_mul.sv
sv/m2a_sum.sv
sv/m2a_div.sv
sv/matrix2x2_fixed_alu.sv
dv/tb_top.sv
